>>> rtl/heightmap_bilinear_sampler_assert.svh
// Assertion macros for the height grid sampler top level.
// Depends on nothing; included by the files that carry assertions.
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_ASSERT_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define HBS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hbs: same-cycle implication failed");

// Next-cycle implication, disabled while reset is low.
`define HBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hbs: next-cycle implication failed");

`endif

>>> rtl/hbs_pkg.sv
// Shared types and constants of the height grid sampler.
// Depends on nothing; imported by the core and the top level.
package hbs_pkg;

    localparam int HEIGHT_W  = 24;
    localparam int COORD_W   = 18;
    localparam int DIST_W    = 16;
    localparam int OP_W      = 2;
    localparam int IDX_W     = 8;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;

    localparam int HBS_MAX_COLS = 256;
    localparam int HBS_MAX_ROWS = 256;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 26;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
    localparam logic [OP_W-1:0] OP_DERIV  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd1;

    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 9'd256;

    // Height 10.0 in Q15.8.
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 24'd2560;

    typedef struct packed {
        logic                      deriv;
        logic signed [COORD_W-1:0] u;
        logic signed [COORD_W-1:0] v;
        logic [DIST_W-1:0]         d;
    } t_job;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_status;

    typedef struct packed {
        logic signed [HEIGHT_W-1:0] height;
        logic signed [HEIGHT_W-1:0] slope_u;
        logic signed [HEIGHT_W-1:0] slope_v;
    } t_result;

endpackage

>>> rtl/hbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; holds the height grid.
module hbs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/hbs_mul.sv
// Shared signed multiplier with a registered product.
// Depends on hbs_pkg for the operand widths.
module hbs_mul import hbs_pkg::*; (
    input  logic                      i_clk,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [MUL_P_W-1:0] o_p
);

    logic signed [MUL_P_W-1:0] r_p;

    // One multiplication per cycle, product registered.
    always_ff @(posedge i_clk) begin
        r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

>>> rtl/hbs_core.sv
// Sequencer and datapath for bilinear samples and central differences.
// Depends on hbs_pkg and hbs_mul; reads the grid through an external RAM port.
module hbs_core import hbs_pkg::*; #(
    parameter int MAX_COLS = HBS_MAX_COLS,
    parameter int MAX_ROWS = HBS_MAX_ROWS
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_start,
    input  t_job                                          i_job,
    input  logic [$clog2(MAX_COLS)-1:0]                   i_cols_m1,
    input  logic [$clog2(MAX_ROWS)-1:0]                   i_rows_m1,
    output logic [$clog2(MAX_COLS)+$clog2(MAX_ROWS)-1:0]  o_rd_addr,
    input  logic [HEIGHT_W-1:0]                           i_rd_data,
    input  logic                                          i_out_free,
    output t_core_status                                  o_status,
    output t_result                                       o_result
);

    localparam int XW    = $clog2(MAX_COLS);
    localparam int YW    = $clog2(MAX_ROWS);
    localparam int ACC_W = 60;
    localparam int A_W   = 42;
    localparam logic signed [ACC_W-1:0] ACC_HALF = 60'sh0000_0008_0000_000;
    localparam logic signed [COORD_W:0] COORD_HI = 19'sd131071;
    localparam logic signed [COORD_W:0] COORD_LO = -19'sd131072;

    typedef enum logic [3:0] {
        S_IDLE, S_MU, S_MV, S_FY, S_R00, S_R10, S_R01, S_R11,
        S_MA, S_MB, S_DF, S_ML, S_MH, S_ACC, S_DIF, S_DONE
    } t_state;

    t_state                     r_state;
    t_job                       r_job;
    logic [1:0]                 r_k;
    logic [XW-1:0]              r_x0, r_x1;
    logic [YW-1:0]              r_y0, r_y1;
    logic [15:0]                r_tx, r_ty;
    logic signed [HEIGHT_W-1:0] r_h00, r_h10, r_h01, r_h11;
    logic signed [A_W-1:0]      r_a, r_d;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [HEIGHT_W-1:0] r_first;
    logic signed [HEIGHT_W-1:0] r_height, r_slope_u, r_slope_v;

    logic signed [MUL_A_W-1:0]  w_mul_a;
    logic signed [MUL_B_W-1:0]  w_mul_b;
    logic signed [MUL_P_W-1:0]  w_prod;
    logic signed [COORD_W-1:0]  w_su, w_sv;
    logic signed [COORD_W:0]    w_d19;
    logic signed [15:0]         w_i0, w_i1;
    logic [15:0]                w_frac;
    logic signed [HEIGHT_W-1:0] w_val;

    // Saturate a 19-bit coordinate sum to the Q2.16 range.
    function automatic logic signed [COORD_W-1:0] sat_coord(logic signed [COORD_W:0] s);
        logic signed [COORD_W-1:0] res;
        if (s > COORD_HI) begin
            res = COORD_HI[COORD_W-1:0];
        end else if (s < COORD_LO) begin
            res = COORD_LO[COORD_W-1:0];
        end else begin
            res = s[COORD_W-1:0];
        end
        return res;
    endfunction

    // Clamp a signed neighbor index to 0..hi.
    function automatic logic [15:0] clamp_idx(logic signed [15:0] x, logic [15:0] hi);
        logic [15:0] res;
        if (x < 16'sd0) begin
            res = 16'd0;
        end else if ($unsigned(x) > hi) begin
            res = hi;
        end else begin
            res = $unsigned(x);
        end
        return res;
    endfunction

    // Difference of two heights saturated to 24 bits.
    function automatic logic signed [HEIGHT_W-1:0] sat_diff(
        logic signed [HEIGHT_W-1:0] a,
        logic signed [HEIGHT_W-1:0] b
    );
        logic signed [HEIGHT_W:0]   s;
        logic signed [HEIGHT_W-1:0] res;
        s = HEIGHT_W'(0) + ((HEIGHT_W+1)'(a) - (HEIGHT_W+1)'(b));
        if (s[HEIGHT_W] != s[HEIGHT_W-1]) begin
            res = s[HEIGHT_W] ? {1'b1, {(HEIGHT_W-1){1'b0}}} : {1'b0, {(HEIGHT_W-1){1'b1}}};
        end else begin
            res = s[HEIGHT_W-1:0];
        end
        return res;
    endfunction

    // Coordinates of the current sample; derivative samples are offset and saturated.
    always_comb begin
        w_d19 = $signed({3'b000, r_job.d});
        w_su  = r_job.u;
        w_sv  = r_job.v;
        if (r_job.deriv) begin
            case (r_k)
                2'd0:    w_su = sat_coord((COORD_W+1)'(r_job.u) - w_d19);
                2'd1:    w_su = sat_coord((COORD_W+1)'(r_job.u) + w_d19);
                2'd2:    w_sv = sat_coord((COORD_W+1)'(r_job.v) - w_d19);
                default: w_sv = sat_coord((COORD_W+1)'(r_job.v) + w_d19);
            endcase
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_MU: begin
                w_mul_a = MUL_A_W'(w_su);
                w_mul_b = $signed(MUL_B_W'(i_cols_m1));
            end
            S_MV: begin
                w_mul_a = MUL_A_W'(w_sv);
                w_mul_b = $signed(MUL_B_W'(i_rows_m1));
            end
            S_MA: begin
                w_mul_a = MUL_A_W'((HEIGHT_W+1)'(r_h10) - (HEIGHT_W+1)'(r_h00));
                w_mul_b = $signed({2'b00, r_tx});
            end
            S_MB: begin
                w_mul_a = MUL_A_W'((HEIGHT_W+1)'(r_h11) - (HEIGHT_W+1)'(r_h01));
                w_mul_b = $signed({2'b00, r_tx});
            end
            S_ML: begin
                w_mul_a = $signed({5'b00000, r_d[20:0]});
                w_mul_b = $signed({2'b00, r_ty});
            end
            S_MH: begin
                w_mul_a = MUL_A_W'($signed(r_d[A_W-1:21]));
                w_mul_b = $signed({2'b00, r_ty});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    hbs_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    // Floor and ceil neighbors of a scaled coordinate held in the product.
    assign w_frac = w_prod[15:0];
    assign w_i0   = $signed(w_prod[31:16]);
    assign w_i1   = w_i0 + $signed({15'd0, (w_frac != 16'd0)});

    // Rounded sample value: bits 55:32 of the scaled sum.
    assign w_val = r_acc[55:32];

    // Grid read address for each of the four neighbor reads.
    always_comb begin
        case (r_state)
            S_R10:   o_rd_addr = {r_x1, r_y0};
            S_R01:   o_rd_addr = {r_x0, r_y1};
            S_R11:   o_rd_addr = {r_x1, r_y1};
            default: o_rd_addr = {r_x0, r_y0};
        endcase
    end

    // Sequencer state and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= 2'd0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_job   <= i_job;
                        r_k     <= 2'd0;
                        r_state <= S_MU;
                    end
                end
                S_MU: begin
                    r_state <= S_MV;
                end
                S_MV: begin
                    r_x0    <= XW'(clamp_idx(w_i0, 16'(i_cols_m1)));
                    r_x1    <= XW'(clamp_idx(w_i1, 16'(i_cols_m1)));
                    r_tx    <= w_frac;
                    r_state <= S_FY;
                end
                S_FY: begin
                    r_y0    <= YW'(clamp_idx(w_i0, 16'(i_rows_m1)));
                    r_y1    <= YW'(clamp_idx(w_i1, 16'(i_rows_m1)));
                    r_ty    <= w_frac;
                    r_state <= S_R00;
                end
                S_R00: begin
                    r_state <= S_R10;
                end
                S_R10: begin
                    r_h00   <= $signed(i_rd_data);
                    r_state <= S_R01;
                end
                S_R01: begin
                    r_h10   <= $signed(i_rd_data);
                    r_state <= S_R11;
                end
                S_R11: begin
                    r_h01   <= $signed(i_rd_data);
                    r_state <= S_MA;
                end
                S_MA: begin
                    r_h11   <= $signed(i_rd_data);
                    r_state <= S_MB;
                end
                S_MB: begin
                    // First row blend: h00 scaled plus tx times the row step.
                    r_a     <= (A_W'(r_h00) <<< 16) + A_W'(w_prod);
                    r_state <= S_DF;
                end
                S_DF: begin
                    // Second row blend minus the first one.
                    r_d     <= (A_W'(r_h01) <<< 16) + A_W'(w_prod) - r_a;
                    r_state <= S_ML;
                end
                S_ML: begin
                    r_state <= S_MH;
                end
                S_MH: begin
                    // Low partial product of ty times the row difference, plus rounding.
                    r_acc   <= (ACC_W'(r_a) <<< 16) + ACC_HALF + ACC_W'(w_prod);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc   <= r_acc + (ACC_W'(w_prod) <<< 21);
                    r_state <= S_DIF;
                end
                S_DIF: begin
                    if (!r_job.deriv) begin
                        r_height  <= w_val;
                        r_slope_u <= '0;
                        r_slope_v <= '0;
                        r_state   <= S_DONE;
                    end else begin
                        r_height <= '0;
                        case (r_k)
                            2'd1:    r_slope_u <= sat_diff(r_first, w_val);
                            2'd3:    r_slope_v <= sat_diff(r_first, w_val);
                            default: r_first   <= w_val;
                        endcase
                        if (r_k == 2'd3) begin
                            r_state <= S_DONE;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= S_MU;
                        end
                    end
                end
                S_DONE: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_status.busy    = (r_state != S_IDLE);
    assign o_status.done    = (r_state == S_DONE) && i_out_free;
    assign o_result.height  = r_height;
    assign o_result.slope_u = r_slope_u;
    assign o_result.slope_v = r_slope_v;

endmodule

>>> rtl/heightmap_bilinear_sampler.sv
// A write is stored in the grid when it is accepted; a height sample runs once through the
// sequencer, a derivative runs four samples in turn on one shared multiplier.
// Writes are taken one per cycle while the sequencer is idle; no new item is taken until
// the sequencer is idle again, and a result waiting on the output holds the sequencer in its
// last state until it is taken. Reset sets both grid sizes to 256 and starts a clearing pass
// of one grid entry per cycle over the whole table, accepting no input items meanwhile.
module heightmap_bilinear_sampler import hbs_pkg::*; #(
    parameter int MAX_COLS = HBS_MAX_COLS,
    parameter int MAX_ROWS = HBS_MAX_ROWS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Input item channel.
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [OP_W-1:0]            i_operation,
    input  logic [IDX_W-1:0]           i_write_col,
    input  logic [IDX_W-1:0]           i_write_row,
    input  logic signed [HEIGHT_W-1:0] i_write_height,
    input  logic signed [COORD_W-1:0]  i_coord_u,
    input  logic signed [COORD_W-1:0]  i_coord_v,
    input  logic [DIST_W-1:0]          i_step_distance,
    // Result channel.
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [HEIGHT_W-1:0] o_height_out,
    output logic signed [HEIGHT_W-1:0] o_slope_u,
    output logic signed [HEIGHT_W-1:0] o_slope_v,
    // Configuration write channel.
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_W-1:0]           i_cfg_data
);

`include "heightmap_bilinear_sampler_assert.svh"

    localparam int XW    = $clog2(MAX_COLS);
    localparam int YW    = $clog2(MAX_ROWS);
    localparam int AW    = XW + YW;
    localparam int DEPTH = 1 << AW;

    logic [CFG_W-1:0]           r_grid_cols, r_grid_rows;
    logic                       r_clr_busy;
    logic [AW-1:0]              r_clr_addr;
    logic                       r_out_valid;
    logic signed [HEIGHT_W-1:0] r_height, r_slope_u, r_slope_v;

    logic                       w_in_fire;
    logic                       w_start;
    logic                       w_wr_hit;
    logic                       w_ram_we;
    logic [AW-1:0]              w_ram_waddr;
    logic [HEIGHT_W-1:0]        w_ram_wdata;
    logic [AW-1:0]              w_rd_addr;
    logic [HEIGHT_W-1:0]        w_rd_data;
    logic [12:0]                w_cols13, w_rows13;
    logic [XW-1:0]              w_cols_m1;
    logic [YW-1:0]              w_rows_m1;
    logic                       w_out_free;
    t_job                       w_job;
    t_core_status               w_status;
    t_result                    w_result;

    // Input handshake.
    assign o_ready   = !r_clr_busy && !w_status.busy;
    assign w_in_fire = i_valid && o_ready;
    assign w_start   = w_in_fire && (i_operation == OP_SAMPLE || i_operation == OP_DERIV);

    // Grid size in use: zero acts as one, sizes above the table clamp to it.
    assign w_cols13 = 13'(r_grid_cols);
    assign w_rows13 = 13'(r_grid_rows);
    assign w_cols_m1 = (r_grid_cols == '0) ? '0 :
                       (w_cols13 > 13'(MAX_COLS)) ? XW'(MAX_COLS - 1) : XW'(w_cols13 - 13'd1);
    assign w_rows_m1 = (r_grid_rows == '0) ? '0 :
                       (w_rows13 > 13'(MAX_ROWS)) ? YW'(MAX_ROWS - 1) : YW'(w_rows13 - 13'd1);

    // Configuration registers; indexes beyond the list are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cols <= CFG_SIZE_RESET;
            r_grid_rows <= CFG_SIZE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_GRID_COLS: r_grid_cols <= i_cfg_data;
                CFG_GRID_ROWS: r_grid_rows <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Clearing pass after reset fills every entry with the reset height.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == {AW{1'b1}}) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Grid write port: clearing pass or a write transaction inside the table.
    assign w_wr_hit = w_in_fire && (i_operation == OP_WRITE)
                      && (32'(i_write_col) < 32'(MAX_COLS))
                      && (32'(i_write_row) < 32'(MAX_ROWS));
    assign w_ram_we    = r_clr_busy || w_wr_hit;
    assign w_ram_waddr = r_clr_busy ? r_clr_addr : {XW'(i_write_col), YW'(i_write_row)};
    assign w_ram_wdata = r_clr_busy ? HEIGHT_RESET : i_write_height;

    hbs_ram #(
        .WIDTH (HEIGHT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    // Job handed to the sequencer.
    assign w_job.deriv = (i_operation == OP_DERIV);
    assign w_job.u     = i_coord_u;
    assign w_job.v     = i_coord_v;
    assign w_job.d     = i_step_distance;

    assign w_out_free = !r_out_valid || i_ready;

    hbs_core #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_job      (w_job),
        .i_cols_m1  (w_cols_m1),
        .i_rows_m1  (w_rows_m1),
        .o_rd_addr  (w_rd_addr),
        .i_rd_data  (w_rd_data),
        .i_out_free (w_out_free),
        .o_status   (w_status),
        .o_result   (w_result)
    );

    // Output register; a finished result loads when the register is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_status.done) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_status.done) begin
            r_height  <= w_result.height;
            r_slope_u <= w_result.slope_u;
            r_slope_v <= w_result.slope_v;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_height_out = r_height;
    assign o_slope_u    = r_slope_u;
    assign o_slope_v    = r_slope_v;

    // No input transaction is taken during the clearing pass.
    `HBS_ASSERT_IMP(a_no_accept_in_clear, i_clk, i_rst_n, r_clr_busy, !o_ready)
    // A result is handed over only when the output register can take it.
    `HBS_ASSERT_IMP(a_done_into_free_reg, i_clk, i_rst_n, w_status.done, w_out_free)
    // Outside the clearing pass the grid is written only by a write transaction.
    `HBS_ASSERT_IMP(a_write_source, i_clk, i_rst_n, w_ram_we && !r_clr_busy,
        w_in_fire && (i_operation == OP_WRITE))
    // A started sample keeps the sequencer busy in the next cycle.
    `HBS_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, w_start, w_status.busy)
    // A finished result shows on the output in the next cycle.
    `HBS_ASSERT_NEXT(a_done_shows, i_clk, i_rst_n, w_status.done, r_out_valid)

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the height grid sampler: directed edge cases, then random
// traffic over several grid sizes, checked against an in-bench bilinear height model.
// Depends on hbs_pkg and heightmap_bilinear_sampler.
module testbench;
    import hbs_pkg::*;

    localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int IDLE_PCT      = 18;
    localparam int SETTLE_CYCLES = 64;
    localparam longint COORD_LO  = -131072;
    localparam longint COORD_HI  = 131071;
    localparam longint HEIGHT_LO = -8388608;
    localparam longint HEIGHT_HI = 8388607;

    typedef struct {
        logic [OP_W-1:0]            op;
        logic [IDX_W-1:0]           col;
        logic [IDX_W-1:0]           row;
        logic signed [HEIGHT_W-1:0] height;
        logic signed [COORD_W-1:0]  u;
        logic signed [COORD_W-1:0]  v;
        logic [DIST_W-1:0]          step;
    } grid_cmd_t;

    typedef struct {
        logic signed [HEIGHT_W-1:0] height;
        logic signed [HEIGHT_W-1:0] slope_u;
        logic signed [HEIGHT_W-1:0] slope_v;
    } height_result_t;

    logic                       i_clk           = 1'b0;
    logic                       i_rst_n         = 1'b0;
    logic                       i_valid         = 1'b0;
    logic                       o_ready;
    logic [OP_W-1:0]            i_operation     = OP_WRITE;
    logic [IDX_W-1:0]           i_write_col     = '0;
    logic [IDX_W-1:0]           i_write_row     = '0;
    logic signed [HEIGHT_W-1:0] i_write_height  = '0;
    logic signed [COORD_W-1:0]  i_coord_u       = '0;
    logic signed [COORD_W-1:0]  i_coord_v       = '0;
    logic [DIST_W-1:0]          i_step_distance = '0;
    logic                       o_valid;
    logic                       i_ready         = 1'b0;
    logic signed [HEIGHT_W-1:0] o_height_out;
    logic signed [HEIGHT_W-1:0] o_slope_u;
    logic signed [HEIGHT_W-1:0] o_slope_v;
    logic                       i_cfg_valid     = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index     = CFG_GRID_COLS;
    logic [CFG_W-1:0]           i_cfg_data      = '0;

    // Model state: the height grid and the two size registers.
    logic signed [HEIGHT_W-1:0] model_grid [0:HBS_MAX_COLS-1][0:HBS_MAX_ROWS-1];
    logic [CFG_W-1:0]           model_cols;
    logic [CFG_W-1:0]           model_rows;
    height_result_t             pending_heights [$];

    bit no_idle = 1'b0;
    int n_errors = 0;
    int n_checked = 0;
    int n_writes = 0;
    int n_samples = 0;
    int n_derivs = 0;
    int n_settings = 0;
    int cycle_count = 0;

    heightmap_bilinear_sampler i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_operation     (i_operation),
        .i_write_col     (i_write_col),
        .i_write_row     (i_write_row),
        .i_write_height  (i_write_height),
        .i_coord_u       (i_coord_u),
        .i_coord_v       (i_coord_v),
        .i_step_distance (i_step_distance),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_height_out    (o_height_out),
        .o_slope_u       (o_slope_u),
        .o_slope_v       (o_slope_v),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, pending_heights.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // The result side stalls at random unless a no-idle stretch is running.
    always @(posedge i_clk) begin
        i_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    function automatic longint clip(input longint x, input longint lo, input longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    // A size register of 0 means one entry; values above the table size saturate.
    function automatic int grid_span(input logic [CFG_W-1:0] r, input int maxv);
        if (r == 0) return 1;
        if (r > maxv) return maxv;
        return int'(r);
    endfunction

    // Bilinear height at Q2.16 coordinates, neighbours clamped to the grid edges,
    // rounded to nearest with ties toward plus infinity.
    function automatic longint bilerp_height(input longint u, input longint v);
        longint cols, rows, pu, pv, x0, y0, x1, y1, tx, ty;
        longint h00, h10, h01, h11, a, b, r;
        cols = grid_span(model_cols, HBS_MAX_COLS);
        rows = grid_span(model_rows, HBS_MAX_ROWS);
        pu = u * (cols - 1);
        pv = v * (rows - 1);
        x0 = pu >>> 16;
        y0 = pv >>> 16;
        tx = pu - x0 * 65536;
        ty = pv - y0 * 65536;
        x1 = (tx != 0) ? x0 + 1 : x0;
        y1 = (ty != 0) ? y0 + 1 : y0;
        x0 = clip(x0, 0, cols - 1);
        x1 = clip(x1, 0, cols - 1);
        y0 = clip(y0, 0, rows - 1);
        y1 = clip(y1, 0, rows - 1);
        h00 = model_grid[x0][y0];
        h10 = model_grid[x1][y0];
        h01 = model_grid[x0][y1];
        h11 = model_grid[x1][y1];
        a = h00 * 65536 + tx * (h10 - h00);
        b = h01 * 65536 + tx * (h11 - h01);
        r = a * 65536 + ty * (b - a) + (longint'(1) <<< 31);
        return r >>> 32;
    endfunction

    // Applies one accepted item to the model and queues the result it should produce.
    function automatic void predict_heights(input grid_cmd_t c);
        height_result_t r;
        longint u, v, d;
        u = $signed(c.u);
        v = $signed(c.v);
        d = longint'(c.step);
        r.height = '0;
        r.slope_u = '0;
        r.slope_v = '0;
        case (c.op)
            OP_WRITE: begin
                model_grid[c.col][c.row] = c.height;
                n_writes++;
            end
            OP_SAMPLE: begin
                r.height = HEIGHT_W'(bilerp_height(u, v));
                pending_heights.push_back(r);
                n_samples++;
            end
            OP_DERIV: begin
                r.slope_u = HEIGHT_W'(clip(bilerp_height(clip(u - d, COORD_LO, COORD_HI), v)
                                 - bilerp_height(clip(u + d, COORD_LO, COORD_HI), v),
                                 HEIGHT_LO, HEIGHT_HI));
                r.slope_v = HEIGHT_W'(clip(bilerp_height(u, clip(v - d, COORD_LO, COORD_HI))
                                 - bilerp_height(u, clip(v + d, COORD_LO, COORD_HI)),
                                 HEIGHT_LO, HEIGHT_HI));
                pending_heights.push_back(r);
                n_derivs++;
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name,
                                        input logic signed [HEIGHT_W-1:0] want,
                                        input logic signed [HEIGHT_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            n_errors++;
        end
    endfunction

    // Each result transaction is compared with the oldest queued expectation.
    always @(posedge i_clk) begin : result_check
        height_result_t want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
            if (pending_heights.size() == 0) begin
                $display("%0t: unexpected result: height %0d, slope_u %0d, slope_v %0d",
                         $time, o_height_out, o_slope_u, o_slope_v);
                n_errors++;
            end else begin
                want = pending_heights.pop_front();
                n_checked++;
                check_field("height_out", want.height, o_height_out);
                check_field("slope_u", want.slope_u, o_slope_u);
                check_field("slope_v", want.slope_v, o_slope_v);
            end
        end
    end

    function automatic grid_cmd_t make_cmd(input logic [OP_W-1:0] op,
                                           input logic [IDX_W-1:0] col,
                                           input logic [IDX_W-1:0] row,
                                           input logic signed [HEIGHT_W-1:0] height,
                                           input logic signed [COORD_W-1:0] u,
                                           input logic signed [COORD_W-1:0] v,
                                           input logic [DIST_W-1:0] step);
        grid_cmd_t c;
        c.op = op;
        c.col = col;
        c.row = row;
        c.height = height;
        c.u = u;
        c.v = v;
        c.step = step;
        return c;
    endfunction

    // Mostly inside the grid in use, sometimes anywhere in the table.
    function automatic logic [IDX_W-1:0] random_index(input int span);
        if ($urandom_range(0, 99) < 80) return IDX_W'($urandom_range(0, span - 1));
        return IDX_W'($urandom);
    endfunction

    // Mostly inside 0..1, some just outside, some anywhere, a few exactly on 0, 0.5 or 1.
    function automatic logic signed [COORD_W-1:0] random_coord();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) return COORD_W'(32768 * $urandom_range(0, 2));
        if (pick < 70) return COORD_W'($urandom_range(0, 65536));
        if (pick < 85) return COORD_W'(int'($urandom_range(0, 98304)) - 16384);
        return COORD_W'($urandom);
    endfunction

    function automatic grid_cmd_t random_cmd();
        grid_cmd_t c;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 38) c.op = OP_WRITE;
        else if (pick < 66) c.op = OP_SAMPLE;
        else if (pick < 96) c.op = OP_DERIV;
        else c.op = OP_IGNORED;
        c.col = random_index(grid_span(model_cols, HBS_MAX_COLS));
        c.row = random_index(grid_span(model_rows, HBS_MAX_ROWS));
        if ($urandom_range(0, 1) == 0) c.height = HEIGHT_W'($urandom);
        else c.height = HEIGHT_W'(int'($urandom_range(0, 131071)) - 65536);
        c.u = random_coord();
        c.v = random_coord();
        pick = $urandom_range(0, 99);
        if (pick < 50) c.step = DIST_W'($urandom_range(0, 4096));
        else if (pick < 85) c.step = DIST_W'($urandom);
        else c.step = ($urandom_range(0, 1) == 0) ? '0 : '1;
        return c;
    endfunction

    // Presents one item and holds it until the input transaction completes.
    // Valid is left high on return so a following item can go out back to back.
    task automatic send_item(input grid_cmd_t c);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) gap = $urandom_range(1, 6);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_operation     <= c.op;
        i_write_col     <= c.col;
        i_write_row     <= c.row;
        i_write_height  <= c.height;
        i_coord_u       <= c.u;
        i_coord_v       <= c.v;
        i_step_distance <= c.step;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
        predict_heights(c);
    endtask

    // Stops sending, waits for every queued result, then lets the block settle.
    task automatic wait_idle(input int settle);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_heights.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        if (idx == CFG_GRID_COLS) model_cols = data;
        else model_rows = data;
    endtask

    task automatic set_grid(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows);
        wait_idle(SETTLE_CYCLES);
        cfg_write(CFG_GRID_COLS, cols);
        cfg_write(CFG_GRID_ROWS, rows);
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic run_random(input int count);
        grid_cmd_t c;
        int sent;
        sent = 0;
        while (sent < count) begin
            c = random_cmd();
            send_item(c);
            if (c.op != OP_IGNORED) sent++;
            // Now and then hold off until every result is back.
            if ($urandom_range(0, 199) == 0) wait_idle(0);
        end
    endtask

    // Fresh grid: a sample at the origin reads back 10.0, a derivative at the centre has flat slopes.
    task automatic test_reset_contents();
        send_item(make_cmd(OP_SAMPLE, 0, 0, 0, 0, 0, 0));
        send_item(make_cmd(OP_DERIV, 0, 0, 0, 32768, 32768, 1000));
    endtask

    // Extreme heights and coordinates, saturated offsets and slopes, the unused opcode.
    task automatic test_edge_cases();
        send_item(make_cmd(OP_WRITE, 0, 0, 24'sh7FFFFF, 0, 0, 0));
        send_item(make_cmd(OP_WRITE, 1, 0, -8388608, 0, 0, 0));
        send_item(make_cmd(OP_WRITE, 0, 1, 24'sh555555, 0, 0, 0));
        send_item(make_cmd(OP_WRITE, 1, 1, 24'shAAAAAA, 0, 0, 0));
        send_item(make_cmd(OP_WRITE, 255, 255, -1, 0, 0, 0));
        send_item(make_cmd(OP_SAMPLE, 0, 0, 0, 0, 0, 0));
        send_item(make_cmd(OP_SAMPLE, 0, 0, 0, -131072, -131072, 0));
        send_item(make_cmd(OP_SAMPLE, 0, 0, 0, 131071, 131071, 0));
        send_item(make_cmd(OP_SAMPLE, 0, 0, 0, 65536, 65536, 0));
        send_item(make_cmd(OP_SAMPLE, 0, 0, 0, 128, 128, 0));
        send_item(make_cmd(OP_SAMPLE, 0, 0, 0, 32768, 0, 0));
        send_item(make_cmd(OP_DERIV, 0, 0, 0, 0, 0, 256));
        send_item(make_cmd(OP_DERIV, 0, 0, 0, 131071, -131072, 16'hFFFF));
        send_item(make_cmd(OP_DERIV, 0, 0, 0, 128, 128, 0));
        send_item(make_cmd(OP_IGNORED, 255, 255, -1, -1, -1, 16'hFFFF));
        send_item(make_cmd(OP_SAMPLE, 0, 0, 0, 128, 128, 0));
        send_item(make_cmd(OP_DERIV, 0, 0, 0, 256, 256, 16'hFFFF));
        send_item(make_cmd(OP_DERIV, 0, 0, 0, -131072, 131071, 16'hFFFF));
    endtask

    // Random traffic across grid sizes, including zero, one and oversized settings.
    // Small grids come first so entries written outside them show up later.
    task automatic test_random_grids();
        int cols [9];
        int rows [9];
        cols = '{2, 1, 0, 5, 17, 3, 256, 511, 0};
        rows = '{2, 1, 0, 3, 200, 256, 2, 257, 0};
        cols[8] = $urandom_range(1, 256);
        rows[8] = $urandom_range(1, 256);
        for (int p = 0; p < 9; p++) begin
            set_grid(CFG_W'(cols[p]), CFG_W'(rows[p]));
            run_random(180);
        end
    endtask

    // Full grid with both sides always ready.
    task automatic test_streaming_no_idle();
        set_grid(CFG_W'(HBS_MAX_COLS), CFG_W'(HBS_MAX_ROWS));
        no_idle = 1'b1;
        run_random(130);
        no_idle = 1'b0;
    endtask

    initial begin
        for (int c = 0; c < HBS_MAX_COLS; c++)
            for (int r = 0; r < HBS_MAX_ROWS; r++)
                model_grid[c][r] = HEIGHT_RESET;
        model_cols = CFG_SIZE_RESET;
        model_rows = CFG_SIZE_RESET;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_contents();
        test_edge_cases();
        test_random_grids();
        test_streaming_no_idle();
        wait_idle(SETTLE_CYCLES);

        $display("Covered %0d writes, %0d height samples and %0d derivatives over %0d grid sizes;",
                 n_writes, n_samples, n_derivs, n_settings);
        $display("%0d results compared, %0d mismatches, %0d cycles.",
                 n_checked, n_errors, cycle_count);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> heightmap_bilinear_sampler.f
+incdir+rtl
rtl/hbs_pkg.sv
rtl/hbs_ram.sv
rtl/hbs_mul.sv
rtl/hbs_core.sv
rtl/heightmap_bilinear_sampler.sv
verif/testbench.sv
